// File: rtl/eedc_pkg.sv
// ----------------------------------------------------------------------------
// eedc_pkg
// Shared types and constants of the edge escape drive controller.
// ----------------------------------------------------------------------------
package eedc_pkg;

  localparam int LEVEL_W    = 10;
  localparam int MODE_W     = 4;
  localparam int CNT_W      = 8;
  localparam int TICK_W     = 16;
  localparam int THR_W      = 10;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_START  = 4'd0,
    MODE_SEARCH = 4'd1,
    MODE_TRACK  = 4'd2,
    MODE_FWD    = 4'd3,
    MODE_FWD_L  = 4'd4,
    MODE_FWD_R  = 4'd5,
    MODE_BACK   = 4'd6,
    MODE_BACK_L = 4'd7,
    MODE_BACK_R = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    SEEN_NONE   = 2'd0,
    SEEN_LEFT   = 2'd1,
    SEEN_RIGHT  = 2'd2,
    SEEN_MIDDLE = 2'd3
  } seen_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONFIRM   = 4'd0,
    REG_ASSIST    = 4'd1,
    REG_THRESHOLD = 4'd2,
    REG_ESCAPE    = 4'd3,
    REG_START     = 4'd4,
    REG_FAST      = 4'd5,
    REG_MEDIUM    = 4'd6,
    REG_SLOW      = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0]   confirm;
    logic [CNT_W-1:0]   assist;
    logic [THR_W-1:0]   threshold;
    logic [TICK_W-1:0]  escape_ticks;
    logic [TICK_W-1:0]  start_ticks;
    logic [LEVEL_W-1:0] fast;
    logic [LEVEL_W-1:0] mid;
    logic [LEVEL_W-1:0] slow;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] lf;
    logic [LEVEL_W-1:0] rf;
    logic [LEVEL_W-1:0] lr;
    logic [LEVEL_W-1:0] rr;
  } levels_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cnt_l;
    logic [CNT_W-1:0]  cnt_r;
    logic [CNT_W-1:0]  cnt_b;
    logic [TICK_W-1:0] esc;
    mode_e             mode;
    seen_e             seen;
    levels_t           lvl;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    confirm:      8'd5,
    assist:       8'd2,
    threshold:    10'd512,
    escape_ticks: 16'd1000,
    start_ticks:  16'd3000,
    fast:         10'd1023,
    mid:          10'd512,
    slow:         10'd256
  };

  localparam state_t STATE_RESET = '{
    cnt_l: '0,
    cnt_r: '0,
    cnt_b: '0,
    esc:   '0,
    mode:  MODE_START,
    seen:  SEEN_NONE,
    lvl:   '0
  };

endpackage

// File: rtl/eedc_sample_if.sv
// ----------------------------------------------------------------------------
// eedc_sample_if
// Sensor sample channel: valid, ready and one set of six samples.
// ----------------------------------------------------------------------------
interface eedc_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] left_line;
  logic [SAMPLE_BITS-1:0] right_line;
  logic [SAMPLE_BITS-1:0] back_line;
  logic [SAMPLE_BITS-1:0] left_range;
  logic [SAMPLE_BITS-1:0] right_range;
  logic [SAMPLE_BITS-1:0] middle_range;

  modport source (
    output valid, left_line, right_line, back_line, left_range, right_range, middle_range,
    input  ready
  );
  modport sink (
    input  valid, left_line, right_line, back_line, left_range, right_range, middle_range,
    output ready
  );
endinterface

// File: rtl/eedc_drive_if.sv
// ----------------------------------------------------------------------------
// eedc_drive_if
// Drive channel: valid, ready, four wheel drive levels and the mode.
// ----------------------------------------------------------------------------
interface eedc_drive_if;
  logic       valid;
  logic       ready;
  logic [9:0] left_forward_drive;
  logic [9:0] right_forward_drive;
  logic [9:0] left_reverse_drive;
  logic [9:0] right_reverse_drive;
  logic [3:0] mode_now;

  modport source (
    output valid, left_forward_drive, right_forward_drive, left_reverse_drive,
           right_reverse_drive, mode_now,
    input  ready
  );
  modport sink (
    input  valid, left_forward_drive, right_forward_drive, left_reverse_drive,
           right_reverse_drive, mode_now,
    output ready
  );
endinterface

// File: rtl/eedc_cfg_regs.sv
// ----------------------------------------------------------------------------
// eedc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module eedc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [eedc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eedc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output eedc_pkg::cfg_t                 cfg_o
);
  import eedc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CONFIRM:   cfg_d.confirm      = cfg_wdata_i[CNT_W-1:0];
        REG_ASSIST:    cfg_d.assist       = cfg_wdata_i[CNT_W-1:0];
        REG_THRESHOLD: cfg_d.threshold    = cfg_wdata_i[THR_W-1:0];
        REG_ESCAPE:    cfg_d.escape_ticks = cfg_wdata_i[TICK_W-1:0];
        REG_START:     cfg_d.start_ticks  = cfg_wdata_i[TICK_W-1:0];
        REG_FAST:      cfg_d.fast         = cfg_wdata_i[LEVEL_W-1:0];
        REG_MEDIUM:    cfg_d.mid          = cfg_wdata_i[LEVEL_W-1:0];
        REG_SLOW:      cfg_d.slow         = cfg_wdata_i[LEVEL_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/eedc_step.sv
// ----------------------------------------------------------------------------
// eedc_step
// Next-state logic for one tick: line counters, escape choice, target
// tracking and the chained mode actions.
// ----------------------------------------------------------------------------
module eedc_step #(
  parameter int SAMPLE_BITS = 10
) (
  input  eedc_pkg::cfg_t         cfg_i,
  input  eedc_pkg::state_t       state_i,
  input  logic [SAMPLE_BITS-1:0] left_line_i,
  input  logic [SAMPLE_BITS-1:0] right_line_i,
  input  logic [SAMPLE_BITS-1:0] back_line_i,
  input  logic [SAMPLE_BITS-1:0] left_range_i,
  input  logic [SAMPLE_BITS-1:0] right_range_i,
  input  logic [SAMPLE_BITS-1:0] middle_range_i,
  output eedc_pkg::state_t       state_o
);
  import eedc_pkg::*;

  localparam int CmpW = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

  logic [CmpW-1:0] thr_x, lr_x, rr_x, mr_x;

  assign thr_x = CmpW'(cfg_i.threshold);
  assign lr_x  = CmpW'(left_range_i);
  assign rr_x  = CmpW'(right_range_i);
  assign mr_x  = CmpW'(middle_range_i);

  always_comb begin
    logic [CNT_W-1:0]  cl, cr, cb;
    logic [TICK_W-1:0] esc, esc_inc, limit;
    mode_e             mode;
    seen_e             seen;
    levels_t           lvl;
    logic              moving;

    // line run counters
    cl = (left_line_i  == '0) ? ((state_i.cnt_l == '1) ? state_i.cnt_l : state_i.cnt_l + 1'b1)
                              : '0;
    cr = (right_line_i == '0) ? ((state_i.cnt_r == '1) ? state_i.cnt_r : state_i.cnt_r + 1'b1)
                              : '0;
    cb = (back_line_i  == '0) ? ((state_i.cnt_b == '1) ? state_i.cnt_b : state_i.cnt_b + 1'b1)
                              : '0;

    // escape choice, later rules win
    mode = state_i.mode;
    if (cl >= cfg_i.confirm) begin
      mode = (cr >= cfg_i.assist) ? MODE_BACK : (cb >= cfg_i.assist) ? MODE_FWD_R : MODE_BACK_L;
    end
    if (cr >= cfg_i.confirm) begin
      mode = (cl >= cfg_i.assist) ? MODE_BACK : (cb >= cfg_i.assist) ? MODE_FWD_L : MODE_BACK_R;
    end
    if (cb >= cfg_i.confirm) begin
      mode = (cr >= cfg_i.assist) ? MODE_FWD_L : (cl >= cfg_i.assist) ? MODE_FWD_R : MODE_FWD;
    end
    esc = (mode != state_i.mode) ? '0 : state_i.esc;

    // target direction
    seen = state_i.seen;
    if (lr_x > thr_x) seen = SEEN_LEFT;
    if (rr_x > thr_x) seen = SEEN_RIGHT;
    if (mr_x > thr_x) seen = SEEN_MIDDLE;

    // move or start action
    lvl    = state_i.lvl;
    moving = 1'b1;
    case (mode)
      MODE_FWD:    lvl = '{cfg_i.fast, cfg_i.fast, '0, '0};
      MODE_FWD_L:  lvl = '{cfg_i.slow, cfg_i.fast, '0, '0};
      MODE_FWD_R:  lvl = '{cfg_i.fast, cfg_i.slow, '0, '0};
      MODE_BACK:   lvl = '{'0, '0, cfg_i.fast, cfg_i.fast};
      MODE_BACK_L: lvl = '{'0, '0, cfg_i.mid, cfg_i.fast};
      MODE_BACK_R: lvl = '{'0, '0, cfg_i.fast, cfg_i.mid};
      MODE_START:  lvl = '{cfg_i.fast, cfg_i.fast, '0, '0};
      default:     moving = 1'b0;
    endcase
    limit   = (mode == MODE_START) ? cfg_i.start_ticks : cfg_i.escape_ticks;
    esc_inc = (esc == '1) ? esc : esc + 1'b1;
    if (moving) begin
      if (esc_inc >= limit) begin
        esc  = '0;
        mode = MODE_SEARCH;
      end else begin
        esc = esc_inc;
      end
    end

    // search
    if (mode == MODE_SEARCH) begin
      if (lr_x < thr_x && mr_x < thr_x && rr_x < thr_x) begin
        mode = (seen == SEEN_RIGHT || seen == SEEN_NONE) ? MODE_FWD_R : MODE_FWD_L;
      end else begin
        mode = MODE_TRACK;
      end
    end

    // track
    if (mode == MODE_TRACK) begin
      esc = '0;
      if (seen != SEEN_NONE) begin
        case (seen)
          SEEN_LEFT:  lvl = '{cfg_i.slow, cfg_i.fast, '0, '0};
          SEEN_RIGHT: lvl = '{cfg_i.fast, cfg_i.slow, '0, '0};
          default:    lvl = '{cfg_i.fast, cfg_i.fast, '0, '0};
        endcase
        if (cfg_i.escape_ticks <= TICK_W'(1)) begin
          mode = MODE_SEARCH;
        end else begin
          esc = TICK_W'(1);
        end
      end
    end

    state_o = '{cnt_l: cl, cnt_r: cr, cnt_b: cb, esc: esc, mode: mode, seen: seen, lvl: lvl};
  end

endmodule

// File: rtl/edge_escape_drive_controller_core.sv
// ----------------------------------------------------------------------------
// edge_escape_drive_controller_core
// Edge escape drive controller: line-sensor escape moves, target search and
// track, four wheel drive levels per tick.
//
//   channel     dir  modport  payload
//   sample_in   in   sink     three line and three range samples
//   drive_out   out  source   four drive levels and mode
//   cfg_*_i     in   -        write enable, register index, write data
//
// One beat per cycle sustained while drive_out is ready; a result passes
// through the input register, then the state register that is also the result.
// The state update is one pass of compare and 8/16-bit increment logic.
// Reset clears both valid flags and loads the reset state and registers.
// A stall on drive_out holds both stages; sample_in stays ready while the
// input register is empty or the result moves on.
// ----------------------------------------------------------------------------
module edge_escape_drive_controller_core #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  eedc_sample_if.sink                    sample_in,
  eedc_drive_if.source                   drive_out,
  input  logic                           cfg_we_i,
  input  logic [eedc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [eedc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import eedc_pkg::*;

  cfg_t   cfg;
  state_t state_q, state_d, state_nxt;

  logic                   in_valid_q, out_valid_q, advance, fire;
  logic [SAMPLE_BITS-1:0] ll_q, rl_q, bl_q, lr_q, rr_q, mr_q;

  eedc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  eedc_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cfg_i          (cfg),
    .state_i        (state_q),
    .left_line_i    (ll_q),
    .right_line_i   (rl_q),
    .back_line_i    (bl_q),
    .left_range_i   (lr_q),
    .right_range_i  (rr_q),
    .middle_range_i (mr_q),
    .state_o        (state_nxt)
  );

  assign advance         = !out_valid_q || drive_out.ready;
  assign fire            = in_valid_q && advance;
  assign sample_in.ready = !in_valid_q || advance;
  assign state_d         = fire ? state_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_RESET;
    end else begin
      if (sample_in.ready) begin
        in_valid_q <= sample_in.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_in.valid && sample_in.ready) begin
      ll_q <= sample_in.left_line;
      rl_q <= sample_in.right_line;
      bl_q <= sample_in.back_line;
      lr_q <= sample_in.left_range;
      rr_q <= sample_in.right_range;
      mr_q <= sample_in.middle_range;
    end
  end

  assign drive_out.valid               = out_valid_q;
  assign drive_out.left_forward_drive  = state_q.lvl.lf;
  assign drive_out.right_forward_drive = state_q.lvl.rf;
  assign drive_out.left_reverse_drive  = state_q.lvl.lr;
  assign drive_out.right_reverse_drive = state_q.lvl.rr;
  assign drive_out.mode_now            = state_q.mode;

endmodule

// File: rtl/eedc_checker.sv
// ----------------------------------------------------------------------------
// eedc_checker
// Port-level checks on the drive channel, bound to the controller core.
// ----------------------------------------------------------------------------
module eedc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [9:0] lf_i,
  input logic [9:0] rf_i,
  input logic [9:0] lr_i,
  input logic [9:0] rr_i,
  input logic [3:0] mode_i
);
  import eedc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !valid_i)
    else $error("drive beat valid during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(lf_i) && $stable(rf_i) && $stable(lr_i)
      && $stable(rr_i) && $stable(mode_i))
    else $error("stalled drive beat changed");

  a_no_fight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (lf_i == '0 && rf_i == '0) || (lr_i == '0 && rr_i == '0))
    else $error("forward and reverse drive both active");

  a_back_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (mode_i == MODE_BACK || mode_i == MODE_BACK_L || mode_i == MODE_BACK_R)
      |-> lf_i == '0 && rf_i == '0)
    else $error("forward drive in a backing mode");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> mode_i <= MODE_BACK_R)
    else $error("mode out of range");

endmodule

bind edge_escape_drive_controller_core eedc_checker u_eedc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .valid_i(drive_out.valid),
  .ready_i(drive_out.ready),
  .lf_i   (drive_out.left_forward_drive),
  .rf_i   (drive_out.right_forward_drive),
  .lr_i   (drive_out.left_reverse_drive),
  .rr_i   (drive_out.right_reverse_drive),
  .mode_i (drive_out.mode_now)
);
